@@ sv/fpt_pkg.sv @@
// Shared types, sizes and codes for the file protection table.
package fpt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IN_TDATA_W  = 264;
    localparam int OUT_TDATA_W = 48;

    localparam logic [1:0] CMD_LOOKUP    = 2'd0;
    localparam logic [1:0] CMD_PROTECT   = 2'd1;
    localparam logic [1:0] CMD_UNPROTECT = 2'd2;
    localparam logic [1:0] CMD_UNLOAD    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic [63:0] volume_hi;
        logic [63:0] volume_lo;
        logic [63:0] file_id_hi;
        logic [63:0] file_id_lo;
    } t_key;

    typedef struct packed {
        t_key       key;
        logic [3:0] deny;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic              valid;
        logic [ADDR_W-1:0] addr;
        t_entry            entry;
    } t_wr_req;

endpackage

@@ sv/fpt_store.sv @@
// Slot memory with per-slot valid flops; registered read, one write port.
module fpt_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [fpt_pkg::ADDR_W-1:0] i_rd_addr,
    output fpt_pkg::t_entry            o_rd_entry,
    output logic                       o_rd_valid,
    input  fpt_pkg::t_wr_req           i_wr
);
    import fpt_pkg::*;

    t_entry                 mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    // entry contents only matter while the slot is valid
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.valid) begin
            mem[i_wr.addr] <= i_wr.entry;
        end
        o_rd_entry <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= i_wr.valid;
            end
            o_rd_valid <= r_valid[i_rd_addr];
        end
    end

endmodule

@@ sv/file_protection_table_unit.sv @@
// Top level of the file protection table: request/response streams and slot scan.
// Usage:
//   Slave stream carries one request word: command, 128-bit volume id,
//   128-bit file id and deny flags. Master stream returns one result word per
//   request: status, deny flags found by a lookup, generation, entry count and
//   the sticky unload flag, all as they stand after the request.
//   Each request walks every slot of the table memory once, one read per
//   cycle, keeping the first matching valid slot and the first free slot;
//   the update and the result are produced in the finish state that
//   follows the last compare, once the output register is empty or its
//   result is being taken. The memory read port sets the pace: the whole
//   table is scanned for a request before the next request is accepted.
//   The result sits in an output register, so a new request is accepted and
//   scanned while the previous result waits; if the receiver still stalls
//   when the next result is ready, the block holds until it is taken.
//   Reset empties the table (valid flops cleared), sets generation to 1,
//   entry count to 0, clears the unload flag and drops the output valid.
module file_protection_table_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // command[1:0], volume_hi[65:2], volume_lo[129:66], file_id_hi[193:130],
    // file_id_lo[257:194], deny_request[261:258], zero pad[263:262]
    input  logic [fpt_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // status[1:0], found_deny[5:2], generation[37:6], entry_count[44:38],
    // unload_allowed[45], zero pad[47:46]
    output logic [fpt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import fpt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_addr;
    logic              r_issue_done;
    logic              r_cmp_en;
    logic [ADDR_W-1:0] r_cmp_addr;

    logic [1:0]        r_cmd;
    t_key              r_key;
    logic [3:0]        r_deny;

    logic              r_hit;
    logic [ADDR_W-1:0] r_hit_addr;
    logic [3:0]        r_hit_deny;
    logic              r_free_ok;
    logic [ADDR_W-1:0] r_free_addr;

    logic [31:0]       r_gen, n_gen;
    logic [CNT_W-1:0]  r_live, n_live;
    logic              r_unload, n_unload;

    logic              r_out_valid;
    logic [1:0]        r_out_status, n_status;
    logic [3:0]        r_out_found, n_found;

    t_entry            rd_entry;
    logic              rd_valid;
    t_wr_req           wr_req;

    logic              accept;
    logic              finish;
    logic              vol_zero;
    logic              key_match;

    fpt_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (r_addr),
        .o_rd_entry (rd_entry),
        .o_rd_valid (rd_valid),
        .i_wr       (wr_req)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign finish          = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);
    assign vol_zero        = (r_key.volume_hi == 64'd0) && (r_key.volume_lo == 64'd0);
    assign key_match       = rd_valid && (rd_entry.key == r_key);

    // decision made once the whole table has been seen
    always_comb begin
        n_status       = ST_OK;
        n_found        = 4'd0;
        n_gen          = r_gen;
        n_live         = r_live;
        n_unload       = r_unload;
        wr_req.en      = 1'b0;
        wr_req.valid   = 1'b1;
        wr_req.addr    = r_hit_addr;
        wr_req.entry   = '{key: r_key, deny: r_deny};
        unique case (r_cmd)
            CMD_LOOKUP: begin
                n_found = r_hit ? r_hit_deny : 4'd0;
            end
            CMD_PROTECT: begin
                if (r_deny == 4'd0 || vol_zero) begin
                    n_status = ST_INVALID;
                end else if (r_hit) begin
                    wr_req.en = finish;
                    n_gen     = r_gen + 32'd1;
                end else if (r_free_ok) begin
                    wr_req.en   = finish;
                    wr_req.addr = r_free_addr;
                    n_live      = r_live + CNT_W'(1);
                    n_gen       = r_gen + 32'd1;
                end else begin
                    n_status = ST_FULL;
                end
            end
            CMD_UNPROTECT: begin
                if (r_deny != 4'd0 || vol_zero) begin
                    n_status = ST_INVALID;
                end else if (r_hit) begin
                    wr_req.en    = finish;
                    wr_req.valid = 1'b0;
                    if (r_live != '0) begin
                        n_live = r_live - CNT_W'(1);
                    end
                    n_gen = r_gen + 32'd1;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            CMD_UNLOAD: begin
                if (r_deny != 4'd0) begin
                    n_status = ST_INVALID;
                end else begin
                    n_unload = 1'b1;
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_cmp_en && r_cmp_addr == LAST_ADDR) n_state = S_FIN;
            end
            S_FIN: begin
                if (finish) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_cmp_en     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_ok    <= 1'b0;
            r_gen        <= 32'd1;
            r_live       <= '0;
            r_unload     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_addr       <= '0;
                r_issue_done <= 1'b0;
                r_cmp_en     <= 1'b0;
                r_hit        <= 1'b0;
                r_free_ok    <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_cmp_en <= !r_issue_done;
                if (!r_issue_done) begin
                    if (r_addr == LAST_ADDR) begin
                        r_issue_done <= 1'b1;
                    end else begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                if (r_cmp_en && key_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (r_cmp_en && !rd_valid && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
            end
            if (finish) begin
                r_gen       <= n_gen;
                r_live      <= n_live;
                r_unload    <= n_unload;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request payload and scan results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_s_axis_tdata[1:0];
            r_key <= '{volume_hi:  i_s_axis_tdata[65:2],
                       volume_lo:  i_s_axis_tdata[129:66],
                       file_id_hi: i_s_axis_tdata[193:130],
                       file_id_lo: i_s_axis_tdata[257:194]};
            r_deny <= i_s_axis_tdata[261:258];
        end
        r_cmp_addr <= r_addr;
        if (r_state == S_SCAN && r_cmp_en && key_match && !r_hit) begin
            r_hit_addr <= r_cmp_addr;
            r_hit_deny <= rd_entry.deny;
        end
        if (r_state == S_SCAN && r_cmp_en && !rd_valid && !r_free_ok) begin
            r_free_addr <= r_cmp_addr;
        end
        if (finish) begin
            r_out_status <= n_status;
            r_out_found  <= n_found;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_unload, 7'(r_live), r_gen, r_out_found, r_out_status};

endmodule

@@ sv/fpt_checker.sv @@
// Port-level checks for the file protection table, bound to the top level.
module fpt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [fpt_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import fpt_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request accepted while a scan is running");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] == ST_FULL
        |-> o_m_axis_tdata[44:38] == 7'(TABLE_DEPTH))
        else $error("table full reported below capacity");

    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared without a scan");

endmodule

bind file_protection_table_unit fpt_checker u_fpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
